// ===== design/spip_pkg.sv =====
// Package for the SPI port with receive FIFO: command and register codes,
// flag bit layout, shared structs and the flag helper functions.
// No dependencies.
package spip_pkg;

    localparam int RX_FIFO_DEPTH = 2;

    // Input commands
    localparam logic [2:0] CMD_TICK  = 3'd0;
    localparam logic [2:0] CMD_WRITE = 3'd1;
    localparam logic [2:0] CMD_READ  = 3'd2;
    localparam logic [2:0] CMD_CLEAR = 3'd3;
    localparam logic [2:0] CMD_BUSIN = 3'd4;

    // Configuration register indexes
    localparam logic [2:0] CFG_PORT_ENABLE = 3'd0;
    localparam logic [2:0] CFG_HOST_MODE   = 3'd1;
    localparam logic [2:0] CFG_DIV_SEL     = 3'd2;
    localparam logic [2:0] CFG_DOUBLE      = 3'd3;
    localparam logic [2:0] CFG_BUFFERED    = 3'd4;
    localparam logic [2:0] CFG_IRQ_EN      = 3'd5;

    // Flag bits (normal and buffered names share positions)
    localparam logic [7:0] FL_OVF   = 8'h01;
    localparam logic [7:0] FL_DRE   = 8'h20;
    localparam logic [7:0] FL_TXC   = 8'h40;
    localparam logic [7:0] FL_WRCOL = 8'h40;
    localparam logic [7:0] FL_RXC   = 8'h80;
    localparam logic [7:0] FL_IF    = 8'h80;
    localparam logic [7:0] EN_BUF   = 8'hf0;
    localparam logic [7:0] EN_NORM  = 8'h01;
    localparam logic [7:0] BUS_IDLE = 8'hff;

    typedef struct packed {
        logic       port_enable;
        logic       host_mode;
        logic [1:0] div_sel;
        logic       double_speed;
        logic       buffered;
        logic [7:0] irq_en;
    } cfg_t;

    typedef struct packed {
        logic req;
        logic buffered;
    } mode_clear_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       bus_out_valid;
        logic [7:0] bus_out_byte;
        logic [7:0] status_flags;
        logic       interrupt_request;
        logic       transfer_active;
    } result_t;

    // Ticks of one host transfer: divider * 8 bits, halved at double speed
    function automatic logic [10:0] transfer_ticks(input logic [1:0] sel, input logic dbl);
        logic [10:0] t;
        begin
            case (sel)
                2'd0:    t = 11'd32;
                2'd1:    t = 11'd128;
                2'd2:    t = 11'd512;
                default: t = 11'd1024;
            endcase
            transfer_ticks = dbl ? (t >> 1) : t;
        end
    endfunction

    // Recompute DRE and TXC of the buffered-mode flags
    function automatic logic [7:0] refresh_flags(input logic [7:0] f, input logic qv,
                                                 input logic txc);
        logic [7:0] r;
        begin
            r = f & ~(FL_DRE | FL_TXC);
            if (!qv)
                r = r | FL_DRE;
            if (txc)
                r = r | FL_TXC;
            refresh_flags = r;
        end
    endfunction

endpackage

// ===== design/spip_cfg.sv =====
// Configuration registers of the SPI port.
// Flags a change of the buffered setting so the core can clear its state.
// Depends on spip_pkg.
module spip_cfg (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [2:0]           cfg_index,
    input  logic [7:0]           cfg_data,
    output spip_pkg::cfg_t       cfg,
    output spip_pkg::mode_clear_t mode_clear
);

    spip_pkg::cfg_t cfg_reg;
    logic           wr;

    assign cfg_ready = 1'b1;
    assign wr        = cfg_valid & cfg_ready;
    assign cfg       = cfg_reg;

    assign mode_clear.req      = wr && (cfg_index == spip_pkg::CFG_BUFFERED)
                                 && (cfg_data[0] != cfg_reg.buffered);
    assign mode_clear.buffered = cfg_data[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (wr)
        begin
            case (cfg_index)
                spip_pkg::CFG_PORT_ENABLE: cfg_reg.port_enable  <= cfg_data[0];
                spip_pkg::CFG_HOST_MODE:   cfg_reg.host_mode    <= cfg_data[0];
                spip_pkg::CFG_DIV_SEL:     cfg_reg.div_sel      <= cfg_data[1:0];
                spip_pkg::CFG_DOUBLE:      cfg_reg.double_speed <= cfg_data[0];
                spip_pkg::CFG_BUFFERED:    cfg_reg.buffered     <= cfg_data[0];
                spip_pkg::CFG_IRQ_EN:      cfg_reg.irq_en       <= cfg_data;
                default:                   cfg_reg              <= cfg_reg;
            endcase
        end
    end

endmodule

// ===== design/spip_core.sv =====
// Input register, port state and the single-pass step logic of the SPI port.
// Produces one result per item; state advances when the item moves on.
// Depends on spip_pkg.
module spip_core (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [2:0]            command,
    input  logic [7:0]            value,
    input  spip_pkg::cfg_t        cfg,
    input  spip_pkg::mode_clear_t mode_clear,
    output logic                  res_valid,
    input  logic                  res_ready,
    output spip_pkg::result_t     res
);

    localparam int RX_DEPTH_M1 = spip_pkg::RX_FIFO_DEPTH - 1;

    // Input register
    logic       ivld_reg;
    logic [2:0] icmd_reg;
    logic [7:0] ival_reg;
    logic       move;

    // Port state
    logic [7:0]  data_reg, flags_reg, shift_reg, queue_reg, last_in_reg;
    logic        busy_reg, shift_vld_reg, queue_vld_reg, head_reg;
    logic [10:0] ticks_reg;
    logic [1:0]  count_reg;
    logic [7:0]  fifo_mem [RX_DEPTH_M1:0];

    logic [7:0]  data_next, flags_next, shift_next, queue_next, last_in_next;
    logic        busy_next, shift_vld_next, queue_vld_next, head_next;
    logic [10:0] ticks_next;
    logic [1:0]  count_next;

    logic        fifo_we;
    logic        fifo_wa;
    logic [7:0]  fifo_wd;
    logic        push;
    logic [7:0]  push_val;
    logic [7:0]  outb, rdata, bus;
    logic        bus_vld, irq;

    assign move      = ivld_reg & res_ready;
    assign in_ready  = ~ivld_reg | move;
    assign res_valid = ivld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ivld_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            ivld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            icmd_reg <= command;
            ival_reg <= value;
        end
    end

    always_comb
    begin
        data_next      = data_reg;
        flags_next     = flags_reg;
        busy_next      = busy_reg;
        ticks_next     = ticks_reg;
        shift_next     = shift_reg;
        shift_vld_next = shift_vld_reg;
        queue_next     = queue_reg;
        queue_vld_next = queue_vld_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        last_in_next   = last_in_reg;
        push           = 1'b0;
        push_val       = ival_reg;
        rdata          = 8'h00;
        bus            = 8'h00;
        bus_vld        = 1'b0;
        outb           = shift_vld_reg ? shift_reg : data_reg;
        fifo_we        = 1'b0;
        fifo_wa        = head_reg ^ count_reg[0];
        fifo_wd        = ival_reg;

        case (icmd_reg)
            spip_pkg::CMD_TICK:
            begin
                if (busy_reg)
                begin
                    if (ticks_reg != 11'd0)
                        ticks_next = ticks_reg - 11'd1;
                    if (ticks_next == 11'd0)
                    begin
                        busy_next = 1'b0;
                        if (cfg.port_enable && cfg.host_mode)
                        begin
                            bus_vld = 1'b1;
                            bus     = outb;
                            if (cfg.buffered)
                            begin
                                push     = 1'b1;
                                push_val = last_in_reg;
                                if (queue_vld_reg)
                                begin
                                    // chain the queued byte into a new transfer
                                    queue_vld_next = 1'b0;
                                    flags_next     = spip_pkg::refresh_flags(flags_reg, 1'b0,
                                                                             1'b0);
                                    busy_next      = 1'b1;
                                    shift_next     = queue_reg;
                                    shift_vld_next = 1'b1;
                                    last_in_next   = spip_pkg::BUS_IDLE;
                                    ticks_next     = spip_pkg::transfer_ticks(cfg.div_sel,
                                                                              cfg.double_speed);
                                end
                                else
                                begin
                                    shift_vld_next = 1'b0;
                                    flags_next     = spip_pkg::refresh_flags(flags_reg, 1'b0,
                                                                             1'b1);
                                end
                            end
                            else
                            begin
                                data_next  = last_in_reg;
                                flags_next = flags_reg | spip_pkg::FL_IF;
                            end
                        end
                    end
                end
            end
            spip_pkg::CMD_WRITE:
            begin
                if (!cfg.port_enable)
                begin
                    data_next = ival_reg;
                end
                else if (cfg.buffered)
                begin
                    flags_next = flags_reg & ~spip_pkg::FL_TXC;
                    if (!busy_reg && !shift_vld_reg)
                    begin
                        flags_next     = spip_pkg::refresh_flags(flags_next, queue_vld_reg,
                                                                 1'b0);
                        shift_next     = ival_reg;
                        shift_vld_next = 1'b1;
                        if (cfg.host_mode)
                        begin
                            busy_next    = 1'b1;
                            last_in_next = spip_pkg::BUS_IDLE;
                            ticks_next   = spip_pkg::transfer_ticks(cfg.div_sel,
                                                                    cfg.double_speed);
                        end
                    end
                    else if (!queue_vld_reg)
                    begin
                        queue_next     = ival_reg;
                        queue_vld_next = 1'b1;
                        flags_next     = spip_pkg::refresh_flags(flags_next, 1'b1, 1'b0);
                    end
                end
                else if (busy_reg)
                begin
                    flags_next = flags_reg | spip_pkg::FL_WRCOL;
                end
                else
                begin
                    data_next = ival_reg;
                    if (cfg.host_mode)
                    begin
                        busy_next      = 1'b1;
                        shift_next     = ival_reg;
                        shift_vld_next = 1'b1;
                        last_in_next   = spip_pkg::BUS_IDLE;
                        ticks_next     = spip_pkg::transfer_ticks(cfg.div_sel,
                                                                  cfg.double_speed);
                    end
                end
            end
            spip_pkg::CMD_READ:
            begin
                rdata = data_reg;
                if (cfg.buffered)
                begin
                    if (count_reg != 2'd0)
                    begin
                        // pop: the next entry, if any, sits at the new head
                        head_next  = ~head_reg;
                        count_next = count_reg - 2'd1;
                        data_next  = (count_next != 2'd0) ? fifo_mem[~head_reg] : 8'h00;
                        if (count_next != 2'd0)
                            flags_next = (flags_reg | spip_pkg::FL_RXC) & ~spip_pkg::FL_OVF;
                        else
                            flags_next = flags_reg & ~(spip_pkg::FL_RXC | spip_pkg::FL_OVF);
                    end
                    else
                    begin
                        flags_next = flags_reg & ~(spip_pkg::FL_RXC | spip_pkg::FL_OVF);
                    end
                end
                else
                begin
                    flags_next = flags_reg & ~spip_pkg::FL_IF;
                end
            end
            spip_pkg::CMD_CLEAR:
            begin
                flags_next = flags_reg & ~ival_reg;
            end
            spip_pkg::CMD_BUSIN:
            begin
                if (cfg.port_enable)
                begin
                    if (cfg.host_mode)
                    begin
                        last_in_next = ival_reg;
                    end
                    else
                    begin
                        bus_vld = 1'b1;
                        bus     = outb;
                        if (cfg.buffered)
                        begin
                            push = 1'b1;
                            if (queue_vld_reg)
                            begin
                                shift_next     = queue_reg;
                                shift_vld_next = 1'b1;
                                queue_vld_next = 1'b0;
                                flags_next     = spip_pkg::refresh_flags(flags_reg, 1'b0,
                                                                         1'b0);
                            end
                            else
                            begin
                                shift_vld_next = 1'b0;
                                flags_next     = spip_pkg::refresh_flags(flags_reg, 1'b0,
                                                                         ~busy_reg);
                            end
                        end
                        else
                        begin
                            data_next  = ival_reg;
                            flags_next = flags_reg | spip_pkg::FL_IF;
                        end
                    end
                end
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase

        // Receive FIFO push; touches only data, count, RXC and overflow
        fifo_wd = push_val;
        if (push)
        begin
            if (count_reg == 2'(spip_pkg::RX_FIFO_DEPTH))
            begin
                flags_next = flags_next | spip_pkg::FL_OVF;
            end
            else
            begin
                fifo_we    = 1'b1;
                count_next = count_reg + 2'd1;
                if (count_reg == 2'd0)
                    data_next = push_val;
                flags_next = flags_next | spip_pkg::FL_RXC;
            end
        end

        if (cfg.buffered)
            irq = (flags_next & cfg.irq_en & spip_pkg::EN_BUF) != 8'h00;
        else
            irq = ((flags_next & spip_pkg::FL_IF) != 8'h00)
                  && ((cfg.irq_en & spip_pkg::EN_NORM) != 8'h00);

        res.read_data         = rdata;
        res.bus_out_valid     = bus_vld;
        res.bus_out_byte      = bus;
        res.status_flags      = flags_next;
        res.interrupt_request = irq;
        res.transfer_active   = busy_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_reg      <= 8'h00;
            flags_reg     <= 8'h00;
            busy_reg      <= 1'b0;
            ticks_reg     <= 11'd0;
            shift_reg     <= 8'h00;
            shift_vld_reg <= 1'b0;
            queue_reg     <= 8'h00;
            queue_vld_reg <= 1'b0;
            head_reg      <= 1'b0;
            count_reg     <= 2'd0;
            last_in_reg   <= spip_pkg::BUS_IDLE;
        end
        else if (mode_clear.req)
        begin
            // drop transfer, queue, FIFO and flags on a change of buffered mode
            busy_reg      <= 1'b0;
            ticks_reg     <= 11'd0;
            shift_vld_reg <= 1'b0;
            queue_vld_reg <= 1'b0;
            head_reg      <= 1'b0;
            count_reg     <= 2'd0;
            flags_reg     <= mode_clear.buffered ? spip_pkg::FL_DRE : 8'h00;
        end
        else if (move)
        begin
            data_reg      <= data_next;
            flags_reg     <= flags_next;
            busy_reg      <= busy_next;
            ticks_reg     <= ticks_next;
            shift_reg     <= shift_next;
            shift_vld_reg <= shift_vld_next;
            queue_reg     <= queue_next;
            queue_vld_reg <= queue_vld_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            last_in_reg   <= last_in_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (move && fifo_we && !mode_clear.req)
        begin
            fifo_mem[fifo_wa] <= fifo_wd;
        end
    end

endmodule

// ===== design/spip_out.sv =====
// Result register of the SPI port: holds one finished item until taken.
// Depends on spip_pkg.
module spip_out (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              res_valid,
    output logic              res_ready,
    input  spip_pkg::result_t res,
    output logic              out_valid,
    input  logic              out_ready,
    output spip_pkg::result_t out_res
);

    logic              vld_reg;
    spip_pkg::result_t res_reg;

    assign res_ready = ~vld_reg | out_ready;
    assign out_valid = vld_reg;
    assign out_res   = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            vld_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            res_reg <= res;
        end
    end

endmodule

// ===== design/spi_port_with_rx_fifo.sv =====
// Top level of the SPI port with receive FIFO.
// Depends on spip_pkg, spip_cfg, spip_core and spip_out.
//
//  channel  handshake              payload
//  in       in_valid / in_ready    command[2:0], value[7:0]
//  out      out_valid / out_ready  read_data, bus_out_valid, bus_out_byte,
//                                  status_flags, interrupt_request, transfer_active
//  cfg      cfg_valid / cfg_ready  cfg_index[2:0], cfg_data[7:0]
//
// One item per clock while the output can take it; an item is held in the input
// register, passes through the step logic between the two registers and is captured
// in the output register.
// Stalls on out_ready hold both registers and back up in_ready.
// Reset is asynchronous and clears control state; cfg writes are always ready.
module spi_port_with_rx_fifo (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [2:0] command,
    input  logic [7:0] value,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] read_data,
    output logic       bus_out_valid,
    output logic [7:0] bus_out_byte,
    output logic [7:0] status_flags,
    output logic       interrupt_request,
    output logic       transfer_active,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [2:0] cfg_index,
    input  logic [7:0] cfg_data
);

    spip_pkg::cfg_t        cfg;
    spip_pkg::mode_clear_t mode_clear;
    spip_pkg::result_t     res, out_res;
    logic                  res_valid, res_ready;

    spip_cfg u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .cfg        (cfg),
        .mode_clear (mode_clear)
    );

    spip_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .command    (command),
        .value      (value),
        .cfg        (cfg),
        .mode_clear (mode_clear),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res)
    );

    spip_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_res   (out_res)
    );

    assign read_data         = out_res.read_data;
    assign bus_out_valid     = out_res.bus_out_valid;
    assign bus_out_byte      = out_res.bus_out_byte;
    assign status_flags      = out_res.status_flags;
    assign interrupt_request = out_res.interrupt_request;
    assign transfer_active   = out_res.transfer_active;

endmodule

// ===== test/spi_port_with_rx_fifo_checker.sv =====
`timescale 1ns / 100ps
// Checker for spi_port_with_rx_fifo: tracks register writes and items, predicts each
// result with its own copy of the port state and compares it field by field.
// Depends on spip_pkg.
module spi_port_with_rx_fifo_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_ready,
    input  logic [2:0] command,
    input  logic [7:0] value,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic [7:0] read_data,
    input  logic       bus_out_valid,
    input  logic [7:0] bus_out_byte,
    input  logic [7:0] status_flags,
    input  logic       interrupt_request,
    input  logic       transfer_active,
    input  logic       cfg_valid,
    input  logic       cfg_ready,
    input  logic [2:0] cfg_index,
    input  logic [7:0] cfg_data,
    output int         pending_results,
    output int         failures
);

    // register settings
    logic       port_en;
    logic       host;
    logic [1:0] div_sel;
    logic       dbl;
    logic       buffered;
    logic [7:0] irq_en;

    // port state
    logic [7:0]  data_q;
    logic [7:0]  flags;
    logic        busy;
    logic [10:0] ticks;
    logic [7:0]  shift_b;
    logic        shift_v;
    logic [7:0]  queue_b;
    logic        queue_v;
    logic [7:0]  rx_mem [2];
    logic        rx_head;
    logic [1:0]  rx_fill;
    logic [7:0]  bus_last;

    spip_pkg::result_t pending_responses [$];
    spip_pkg::result_t want;
    int                mismatch_count = 0;

    function automatic void reset_model();
        port_en   = 1'b0;
        host      = 1'b0;
        div_sel   = 2'd0;
        dbl       = 1'b0;
        buffered  = 1'b0;
        irq_en    = 8'h00;
        data_q    = 8'h00;
        flags     = 8'h00;
        busy      = 1'b0;
        ticks     = 11'd0;
        shift_b   = 8'h00;
        shift_v   = 1'b0;
        queue_b   = 8'h00;
        queue_v   = 1'b0;
        rx_mem[0] = 8'h00;
        rx_mem[1] = 8'h00;
        rx_head   = 1'b0;
        rx_fill   = 2'd0;
        bus_last  = spip_pkg::BUS_IDLE;
    endfunction

    function automatic logic [10:0] xfer_ticks();
        logic [10:0] per_bit;
        case (div_sel)
            2'd0:    per_bit = 11'd4;
            2'd1:    per_bit = 11'd16;
            2'd2:    per_bit = 11'd64;
            default: per_bit = 11'd128;
        endcase
        if (dbl)
            per_bit = per_bit >> 1;
        return per_bit << 3;
    endfunction

    function automatic void update_dre_txc(input logic complete);
        logic [7:0] f;
        f = flags & ~(spip_pkg::FL_DRE | spip_pkg::FL_TXC);
        if (!queue_v)
            f = f | spip_pkg::FL_DRE;
        if (complete && !busy && !queue_v && !shift_v)
            f = f | spip_pkg::FL_TXC;
        flags = f;
    endfunction

    function automatic void rx_push(input logic [7:0] b);
        if (rx_fill >= spip_pkg::RX_FIFO_DEPTH)
        begin
            flags = flags | spip_pkg::FL_OVF;
        end
        else
        begin
            rx_mem[rx_head ^ rx_fill[0]] = b;
            rx_fill = rx_fill + 2'd1;
            if (rx_fill == 2'd1)
                data_q = b;
            flags = flags | spip_pkg::FL_RXC;
        end
    endfunction

    function automatic void rx_pop();
        logic [7:0] nxt;
        nxt = 8'h00;
        if (rx_fill != 2'd0)
        begin
            rx_head = ~rx_head;
            rx_fill = rx_fill - 2'd1;
            if (rx_fill != 2'd0)
                nxt = rx_mem[rx_head];
        end
        data_q = nxt;
        if (rx_fill != 2'd0)
            flags = flags | spip_pkg::FL_RXC;
        else
            flags = flags & ~spip_pkg::FL_RXC;
        flags = flags & ~spip_pkg::FL_OVF;
    endfunction

    function automatic void launch_transfer(input logic [7:0] b);
        busy     = 1'b1;
        shift_b  = b;
        shift_v  = 1'b1;
        bus_last = spip_pkg::BUS_IDLE;
        ticks    = xfer_ticks();
    endfunction

    function automatic void end_transfer(output logic drove, output logic [7:0] b);
        logic [7:0] outb;
        logic [7:0] nxt;
        outb  = shift_v ? shift_b : data_q;
        busy  = 1'b0;
        drove = 1'b0;
        b     = 8'h00;
        // nothing goes on the bus once the port is off or has turned client
        if (port_en && host)
        begin
            drove = 1'b1;
            b     = outb;
            if (buffered)
            begin
                rx_push(bus_last);
                if (queue_v)
                begin
                    nxt     = queue_b;
                    queue_v = 1'b0;
                    update_dre_txc(1'b0);
                    launch_transfer(nxt);
                end
                else
                begin
                    shift_v = 1'b0;
                    update_dre_txc(1'b1);
                end
            end
            else
            begin
                data_q = bus_last;
                flags  = flags | spip_pkg::FL_IF;
            end
        end
    endfunction

    function automatic void put_data(input logic [7:0] v);
        if (!port_en)
        begin
            data_q = v;
        end
        else if (buffered)
        begin
            flags = flags & ~spip_pkg::FL_TXC;
            if (!busy && !shift_v)
            begin
                update_dre_txc(1'b0);
                if (host)
                begin
                    launch_transfer(v);
                end
                else
                begin
                    shift_b = v;
                    shift_v = 1'b1;
                end
            end
            else if (!queue_v)
            begin
                queue_b = v;
                queue_v = 1'b1;
                update_dre_txc(1'b0);
            end
        end
        else if (busy)
        begin
            flags = flags | spip_pkg::FL_WRCOL;
        end
        else
        begin
            data_q = v;
            if (host)
                launch_transfer(v);
        end
    endfunction

    function automatic logic [7:0] take_data();
        logic [7:0] v;
        v = data_q;
        if (buffered)
        begin
            if (rx_fill != 2'd0)
                rx_pop();
            else
                flags = flags & ~(spip_pkg::FL_RXC | spip_pkg::FL_OVF);
        end
        else
        begin
            flags = flags & ~spip_pkg::FL_IF;
        end
        return v;
    endfunction

    function automatic void take_bus_byte(input logic [7:0] v, output logic drove,
                                          output logic [7:0] b);
        logic [7:0] outb;
        drove = 1'b0;
        b     = 8'h00;
        if (port_en && host)
        begin
            bus_last = v;
        end
        else if (port_en)
        begin
            // client: echo the transmit byte right away
            outb = shift_v ? shift_b : data_q;
            if (buffered)
            begin
                rx_push(v);
                if (queue_v)
                begin
                    shift_b = queue_b;
                    shift_v = 1'b1;
                    queue_v = 1'b0;
                    update_dre_txc(1'b0);
                end
                else
                begin
                    shift_v = 1'b0;
                    update_dre_txc(1'b1);
                end
                if (rx_fill == 2'd0)
                    data_q = v;
                else if (rx_fill == 2'd1)
                    data_q = rx_mem[rx_head];
            end
            else
            begin
                data_q = v;
                flags  = flags | spip_pkg::FL_IF;
            end
            drove = 1'b1;
            b     = outb;
        end
    endfunction

    function automatic void write_register(input logic [2:0] idx, input logic [7:0] d);
        case (idx)
            spip_pkg::CFG_PORT_ENABLE: port_en = d[0];
            spip_pkg::CFG_HOST_MODE:   host    = d[0];
            spip_pkg::CFG_DIV_SEL:     div_sel = d[1:0];
            spip_pkg::CFG_DOUBLE:      dbl     = d[0];
            spip_pkg::CFG_BUFFERED:
            begin
                // a mode change drops the transfer, queue, FIFO and flags
                if (d[0] != buffered)
                begin
                    buffered = d[0];
                    busy     = 1'b0;
                    ticks    = 11'd0;
                    shift_v  = 1'b0;
                    queue_v  = 1'b0;
                    rx_head  = 1'b0;
                    rx_fill  = 2'd0;
                    flags    = 8'h00;
                    if (buffered)
                        update_dre_txc(1'b0);
                end
            end
            spip_pkg::CFG_IRQ_EN:      irq_en  = d;
            default:                   ;
        endcase
    endfunction

    function automatic spip_pkg::result_t spi_response(input logic [2:0] cmd,
                                                      input logic [7:0] v);
        spip_pkg::result_t r;
        logic              drove;
        logic [7:0]        b;
        r     = '0;
        drove = 1'b0;
        b     = 8'h00;
        case (cmd)
            spip_pkg::CMD_TICK:
            begin
                if (busy)
                begin
                    if (ticks != 11'd0)
                        ticks = ticks - 11'd1;
                    if (ticks == 11'd0)
                        end_transfer(drove, b);
                end
            end
            spip_pkg::CMD_WRITE: put_data(v);
            spip_pkg::CMD_READ:  r.read_data = take_data();
            spip_pkg::CMD_CLEAR: flags = flags & ~v;
            spip_pkg::CMD_BUSIN: take_bus_byte(v, drove, b);
            default:             ;
        endcase
        if (buffered)
            r.interrupt_request = (flags & irq_en & spip_pkg::EN_BUF) != 8'h00;
        else
            r.interrupt_request = ((flags & spip_pkg::FL_IF) != 8'h00)
                                  && ((irq_en & spip_pkg::EN_NORM) != 8'h00);
        r.bus_out_valid   = drove;
        r.bus_out_byte    = drove ? b : 8'h00;
        r.status_flags    = flags;
        r.transfer_active = busy;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [7:0] exp_v,
                                        input logic [7:0] act_v);
        if (act_v !== exp_v)
        begin
            $error("%s: expected %02h, got %02h", name, exp_v, act_v);
            mismatch_count++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reset_model();
            pending_responses.delete();
            pending_results <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                write_register(cfg_index, cfg_data);
            // retire the oldest result before queueing a new item
            if (out_valid && out_ready)
            begin
                if (pending_responses.size() == 0)
                begin
                    $error("result arrived with no item outstanding");
                    mismatch_count++;
                end
                else
                begin
                    want = pending_responses.pop_front();
                    check_field("read_data", want.read_data, read_data);
                    check_field("bus_out_valid", {7'd0, want.bus_out_valid},
                                {7'd0, bus_out_valid});
                    check_field("bus_out_byte", want.bus_out_byte, bus_out_byte);
                    check_field("status_flags", want.status_flags, status_flags);
                    check_field("interrupt_request", {7'd0, want.interrupt_request},
                                {7'd0, interrupt_request});
                    check_field("transfer_active", {7'd0, want.transfer_active},
                                {7'd0, transfer_active});
                end
            end
            if (in_valid && in_ready)
                pending_responses.push_back(spi_response(command, value));
            pending_results <= pending_responses.size();
        end
        failures <= mismatch_count;
    end

endmodule

// ===== test/spi_port_with_rx_fifo_tb.sv =====
`timescale 1ns / 100ps
// Top of the spi_port_with_rx_fifo testbench: clock, reset, register setup and
// item stimulus with random idling; verdict from spi_port_with_rx_fifo_checker.
// Depends on spip_pkg, the RTL and the checker.
module spi_port_with_rx_fifo_tb;

    localparam logic [2:0] CMD_ALL_ONES = 3'd7;
    localparam int         STALL_LIMIT  = 5000;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [2:0] command;
    logic [7:0] value;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] read_data;
    logic       bus_out_valid;
    logic [7:0] bus_out_byte;
    logic [7:0] status_flags;
    logic       interrupt_request;
    logic       transfer_active;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [2:0] cfg_index;
    logic [7:0] cfg_data;

    int pending_results;
    int failures;
    int items_sent    = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int stall_cycles  = 0;

    // settings last written, used only to shape the stimulus
    logic       cur_host;
    logic [1:0] cur_sel;
    logic       cur_dbl;
    logic       cur_buffered;

    spi_port_with_rx_fifo u_top (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .command           (command),
        .value             (value),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .read_data         (read_data),
        .bus_out_valid     (bus_out_valid),
        .bus_out_byte      (bus_out_byte),
        .status_flags      (status_flags),
        .interrupt_request (interrupt_request),
        .transfer_active   (transfer_active),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    spi_port_with_rx_fifo_checker u_checker (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .command           (command),
        .value             (value),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .read_data         (read_data),
        .bus_out_valid     (bus_out_valid),
        .bus_out_byte      (bus_out_byte),
        .status_flags      (status_flags),
        .interrupt_request (interrupt_request),
        .transfer_active   (transfer_active),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .pending_results   (pending_results),
        .failures          (failures)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // end the run when no channel moves for too long
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("spi_port_with_rx_fifo: mismatch");
            $finish;
        end
    end

    function automatic int xfer_len();
        int per_bit;
        case (cur_sel)
            2'd0:    per_bit = 4;
            2'd1:    per_bit = 16;
            2'd2:    per_bit = 64;
            default: per_bit = 128;
        endcase
        if (cur_dbl)
            per_bit = per_bit / 2;
        return per_bit * 8;
    endfunction

    task automatic send_item(input logic [2:0] cmd, input logic [7:0] v);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        command  <= cmd;
        value    <= v;
        do
            @(posedge clk);
        while (!in_ready);
        items_sent++;
    endtask

    // hold off items until every result is back
    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results != 0);
    endtask

    // leaves cfg_valid high so that back-to-back writes need one assignment per edge
    task automatic write_reg(input logic [2:0] idx, input logic [7:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    task automatic program_regs(input logic en, input logic host, input logic [1:0] sel,
                                input logic dbl, input logic bufm, input logic [7:0] irq);
        cur_host     = host;
        cur_sel      = sel;
        cur_dbl      = dbl;
        cur_buffered = bufm;
        write_reg(spip_pkg::CFG_PORT_ENABLE, {7'd0, en});
        write_reg(spip_pkg::CFG_HOST_MODE, {7'd0, host});
        write_reg(spip_pkg::CFG_DIV_SEL, {6'd0, sel});
        write_reg(spip_pkg::CFG_DOUBLE, {7'd0, dbl});
        write_reg(spip_pkg::CFG_BUFFERED, {7'd0, bufm});
        write_reg(spip_pkg::CFG_IRQ_EN, irq);
        cfg_valid <= 1'b0;
    endtask

    task automatic host_transfer();
        int   n;
        logic queued;
        queued = 1'b0;
        send_item(spip_pkg::CMD_WRITE, 8'($urandom));
        if ($urandom_range(1))
            send_item(spip_pkg::CMD_BUSIN, 8'($urandom));
        if (cur_buffered && $urandom_range(1))
        begin
            queued = 1'b1;
            send_item(spip_pkg::CMD_WRITE, 8'($urandom));
        end
        // a further write to a busy port collides in normal mode, or fills or finds the queue full
        if ($urandom_range(3) == 0)
            send_item(spip_pkg::CMD_WRITE, 8'($urandom));
        n = xfer_len() * (queued ? 2 : 1);
        if ($urandom_range(4) == 0)
            n = $urandom_range(n, 1);
        else
            n = n + $urandom_range(2);
        repeat (n)
        begin
            if ($urandom_range(15) == 0)
                send_item(spip_pkg::CMD_BUSIN, 8'($urandom));
            send_item(spip_pkg::CMD_TICK, 8'($urandom));
        end
        if ($urandom_range(1))
            send_item(spip_pkg::CMD_READ, 8'($urandom));
    endtask

    // start a transfer at a long divider and tick through only part of it
    task automatic partial_transfer();
        send_item(spip_pkg::CMD_WRITE, 8'($urandom));
        repeat ($urandom_range(40, 8))
            send_item(spip_pkg::CMD_TICK, 8'($urandom));
    endtask

    task automatic random_burst();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 5)
        begin
            send_item(3'($urandom), 8'($urandom));
        end
        else if (pick < 50 && cur_host)
        begin
            host_transfer();
        end
        else if (pick < 50)
        begin
            if ($urandom_range(3) != 0)
                send_item(spip_pkg::CMD_WRITE, 8'($urandom));
            if ($urandom_range(3) == 0)
                send_item(spip_pkg::CMD_WRITE, 8'($urandom));
            repeat ($urandom_range(3, 1))
                send_item(spip_pkg::CMD_BUSIN, 8'($urandom));
            repeat ($urandom_range(3))
                send_item(spip_pkg::CMD_READ, 8'($urandom));
        end
        else if (pick < 65)
        begin
            send_item(spip_pkg::CMD_READ, 8'($urandom));
        end
        else if (pick < 75)
        begin
            if ($urandom_range(1))
                send_item(spip_pkg::CMD_CLEAR, 8'($urandom));
            else
                send_item(spip_pkg::CMD_CLEAR, 8'h01 << $urandom_range(7));
        end
        else if (pick < 85)
        begin
            repeat ($urandom_range(20, 1))
                send_item(spip_pkg::CMD_TICK, 8'($urandom));
        end
        else if (pick < 93)
        begin
            send_item(spip_pkg::CMD_BUSIN, 8'($urandom));
        end
        else
        begin
            send_item(spip_pkg::CMD_WRITE, 8'($urandom));
        end
    endtask

    task automatic run_phase(input logic en, input logic host, input logic [1:0] sel,
                             input logic dbl, input logic bufm, input logic [7:0] irq,
                             input int budget);
        int start;
        wait_drained();
        program_regs(en, host, sel, dbl, bufm, irq);
        start = items_sent;
        while (items_sent - start < budget)
        begin
            random_burst();
            if ($urandom_range(29) == 0)
                wait_drained();
        end
        // leave a transfer running into the next setting now and then
        if (en && host && $urandom_range(1))
            send_item(spip_pkg::CMD_WRITE, 8'($urandom));
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        command   <= spip_pkg::CMD_TICK;
        value     <= 8'h00;
        cfg_valid <= 1'b0;
        cfg_index <= spip_pkg::CFG_PORT_ENABLE;
        cfg_data  <= 8'h00;
        cur_host     = 1'b0;
        cur_sel      = 2'd0;
        cur_dbl      = 1'b0;
        cur_buffered = 1'b0;
        send_idle_pct = 35;
        recv_idle_pct = 84;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // port off: writes only store, bus bytes are ignored, unknown commands do nothing
        send_item(spip_pkg::CMD_WRITE, 8'h00);
        send_item(spip_pkg::CMD_WRITE, 8'hff);
        send_item(spip_pkg::CMD_READ, 8'h00);
        send_item(spip_pkg::CMD_BUSIN, 8'h00);
        send_item(spip_pkg::CMD_CLEAR, 8'hff);
        send_item(spip_pkg::CMD_TICK, 8'hff);
        send_item(spip_pkg::CMD_BUSIN + 3'd1, 8'h81);
        send_item(CMD_ALL_ONES, 8'hff);
        wait_drained();

        // host transfer in normal mode with a write collision
        program_regs(1'b1, 1'b1, 2'd0, 1'b1, 1'b0, spip_pkg::EN_NORM);
        send_item(spip_pkg::CMD_WRITE, 8'ha5);
        send_item(spip_pkg::CMD_WRITE, 8'h11);
        send_item(spip_pkg::CMD_BUSIN, 8'h7e);
        repeat (xfer_len())
            send_item(spip_pkg::CMD_TICK, 8'h00);
        send_item(spip_pkg::CMD_READ, 8'h00);
        send_item(spip_pkg::CMD_CLEAR, spip_pkg::FL_WRCOL);

        run_phase(1'b1, 1'b1, 2'd0, 1'b1, 1'b0, spip_pkg::EN_NORM, 25);
        run_phase(1'b1, 1'b0, 2'd0, 1'b0, 1'b0, spip_pkg::EN_NORM, 15);
        run_phase(1'b1, 1'b1, 2'd0, 1'b0, 1'b1, spip_pkg::EN_BUF, 25);
        run_phase(1'b0, 1'b1, 2'd0, 1'b1, 1'b1, 8'hff, 10);

        send_idle_pct = 84;
        recv_idle_pct = 35;
        run_phase(1'b1, 1'b0, 2'd1, 1'b1, 1'b1, 8'ha0, 25);
        run_phase(1'b1, 1'b1, 2'd1, 1'b1, 1'b1, 8'h50, 15);
        run_phase(1'b1, 1'b1, 2'd3, 1'b0, 1'b0, 8'h00, 0);
        partial_transfer();
        run_phase(1'b1, 1'b0, 2'd0, 1'b1, 1'b0, 8'hff, 15);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_phase(1'b1, 1'b1, 2'd2, 1'b1, 1'b1, 8'h30, 0);
        partial_transfer();
        run_phase(1'b1, 1'b1, 2'd0, 1'b1, 1'b1, 8'hc0, 25);
        run_phase(1'b1, 1'b0, 2'd3, 1'b1, 1'b1, 8'h10, 25);
        run_phase(1'b1, 1'b1, 2'd0, 1'b1, 1'b0, 8'hfe, 25);

        wait_drained();
        repeat (10) @(posedge clk);
        if (failures == 0 && pending_results == 0)
            $display("spi_port_with_rx_fifo: match");
        else
            $display("spi_port_with_rx_fifo: mismatch");
        $finish;
    end

endmodule
